FILE: rtl/core/gha_pkg.sv
// Package of the generational handle allocator: handle layout, operation codes,
// slot table entry, free stack control and status types, and sequencer states.
// No dependencies.
package gha_pkg;

  localparam int HANDLE_W  = 32;
  localparam int INDEX_W   = 24;
  localparam int GEN_W     = 8;
  localparam int OP_W      = 3;
  localparam int DATA_W    = 64;
  localparam int COUNT_W   = 9;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_QUERY = 3'd2,
    OP_SET   = 3'd3,
    OP_GET   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_POP
  } state_t;

  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic             alive;
    logic             has_data;
  } slot_entry_t;

  typedef struct packed {
    logic peek;
    logic pop;
    logic push;
  } stk_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_sts_t;

endpackage

FILE: rtl/core/gha_if.sv
// Request and result channel interfaces of the generational handle allocator.
// Depends on gha_pkg for the field widths.
interface gha_req_if;
  import gha_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [HANDLE_W-1:0] handle;
  logic [DATA_W-1:0]   payload;
  modport source (output valid, output op, output handle, output payload, input ready);
  modport sink (input valid, input op, input handle, input payload, output ready);
endinterface

interface gha_rsp_if;
  import gha_pkg::*;
  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] new_handle;
  logic                ok;
  logic [DATA_W-1:0]   payload_out;
  logic [COUNT_W-1:0]  live_total;
  logic [COUNT_W-1:0]  slots_used;
  modport source (output valid, output new_handle, output ok, output payload_out,
                  output live_total, output slots_used, input ready);
  modport sink (input valid, input new_handle, input ok, input payload_out,
                input live_total, input slots_used, output ready);
endinterface

FILE: rtl/core/generational_handle_allocator.sv
// Top level of the generational handle allocator: control sequencer, slot table,
// payload memory, free stack and result register. Depends on gha_pkg, gha_if,
// gha_ram and gha_free_stack.
//
// The block hands out 32-bit handles (generation in bits 31..24, slot index plus
// one in bits 23..0) and checks them on free, query, set and get. One word is
// handled at a time. Its result is loaded into the output register at the clock
// edge after the one that accepts it. When an allocate reuses a freed slot, the
// result is loaded one edge later, because the slot table has one read port with
// registered read data and the popped index must be read from the stack before
// its table entry. A word thus passes through the look state, and for such an
// allocate also the pop state, and loading waits while the output is stalled. A new
// word is accepted in the cycle after the previous result is loaded, while that
// result may still wait at the output. The slot table needs no clearing after
// reset: entries at or above the count of slots ever used never affect a result.
module generational_handle_allocator #(
  parameter int SLOTS = 256,
  parameter int PAYLOAD_WIDTH = 64,
  localparam int IDX_W = $clog2(SLOTS),
  localparam int CNT_W = $clog2(SLOTS + 1)
) (
  input logic   clk,
  input logic   rst_n,
  gha_req_if.sink   in_req,
  gha_rsp_if.source out_rsp
);
  import gha_pkg::*;

  state_t state_r, state_nxt;
  logic [OP_W-1:0]          op_r;
  logic [HANDLE_W-1:0]      handle_r;
  logic [PAYLOAD_WIDTH-1:0] payload_r;
  logic [CNT_W-1:0]         hw_r, hw_nxt;
  logic [CNT_W-1:0]         alive_r, alive_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [HANDLE_W-1:0] nh_r, nh_nxt;
  logic                ok_r, ok_nxt;
  logic [DATA_W-1:0]   pout_r, pout_nxt;
  logic [COUNT_W-1:0]  live_r, used_r;

  logic accept;
  logic out_free;
  logic load_out;

  logic [INDEX_W-1:0] req_biased;
  logic [IDX_W-1:0]   req_idx;
  logic [INDEX_W-1:0] cur_biased;
  logic [IDX_W-1:0]   cur_idx;
  logic               resolve_ok;

  logic              tbl_re, tbl_we;
  logic [IDX_W-1:0]  tbl_raddr, tbl_waddr;
  slot_entry_t       tbl_wdata, tbl_q;
  logic              pay_re, pay_we;
  logic [PAYLOAD_WIDTH-1:0] pay_q;

  stk_ctl_t          stk_ctl;
  stk_sts_t          stk_sts;
  logic [IDX_W-1:0]  stk_top;

  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;

  assign req_biased = in_req.handle[INDEX_W-1:0];
  assign req_idx    = IDX_W'(req_biased - INDEX_W'(1));
  assign cur_biased = handle_r[INDEX_W-1:0];
  assign cur_idx    = IDX_W'(cur_biased - INDEX_W'(1));

  // A handle resolves when its index lies below the used count, the slot is
  // alive and the generation matches.
  assign resolve_ok = (cur_biased != '0)
                   && ({1'b0, cur_biased} <= (INDEX_W + 1)'(hw_r))
                   && tbl_q.alive
                   && (tbl_q.gen == handle_r[HANDLE_W-1:INDEX_W]);

  always_comb begin
    state_nxt = state_r;
    hw_nxt    = hw_r;
    alive_nxt = alive_r;
    tbl_re    = 1'b0;
    tbl_raddr = req_idx;
    tbl_we    = 1'b0;
    tbl_waddr = cur_idx;
    tbl_wdata = tbl_q;
    pay_re    = 1'b0;
    pay_we    = 1'b0;
    stk_ctl   = '0;
    load_out  = 1'b0;
    nh_nxt    = '0;
    ok_nxt    = 1'b0;
    pout_nxt  = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          tbl_re       = 1'b1;
          pay_re       = 1'b1;
          stk_ctl.peek = 1'b1;
          state_nxt    = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if ((op_r == OP_ALLOC) && !stk_sts.empty) begin
          tbl_re    = 1'b1;
          tbl_raddr = stk_top;
          state_nxt = ST_POP;
        end else if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
          case (op_r)
            OP_ALLOC: begin
              if (hw_r < CNT_W'(SLOTS)) begin
                tbl_we    = 1'b1;
                tbl_waddr = hw_r[IDX_W-1:0];
                tbl_wdata = '{gen: '0, alive: 1'b1, has_data: 1'b0};
                hw_nxt    = hw_r + CNT_W'(1);
                alive_nxt = alive_r + CNT_W'(1);
                nh_nxt    = {GEN_W'(0), INDEX_W'(hw_r) + INDEX_W'(1)};
                ok_nxt    = 1'b1;
              end
            end
            OP_FREE: begin
              if (resolve_ok && !stk_sts.full) begin
                tbl_we       = 1'b1;
                tbl_wdata    = '{gen: tbl_q.gen + GEN_W'(1), alive: 1'b0, has_data: 1'b0};
                stk_ctl.push = 1'b1;
                alive_nxt    = alive_r - CNT_W'(1);
                ok_nxt       = 1'b1;
              end
            end
            OP_QUERY: begin
              ok_nxt = resolve_ok;
            end
            OP_SET: begin
              if (resolve_ok) begin
                tbl_we    = 1'b1;
                tbl_wdata = '{gen: tbl_q.gen, alive: 1'b1, has_data: 1'b1};
                pay_we    = 1'b1;
                ok_nxt    = 1'b1;
              end
            end
            OP_GET: begin
              if (resolve_ok && tbl_q.has_data) begin
                ok_nxt   = 1'b1;
                pout_nxt = DATA_W'(pay_q);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        if (out_free) begin
          stk_ctl.pop = 1'b1;
          tbl_we      = 1'b1;
          tbl_waddr   = stk_top;
          tbl_wdata   = '{gen: tbl_q.gen, alive: 1'b1, has_data: tbl_q.has_data};
          alive_nxt   = alive_r + CNT_W'(1);
          nh_nxt      = {tbl_q.gen, INDEX_W'(stk_top) + INDEX_W'(1)};
          ok_nxt      = 1'b1;
          load_out    = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_rsp.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hw_r        <= '0;
      alive_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hw_r        <= hw_nxt;
      alive_r     <= alive_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_req.op;
      handle_r  <= in_req.handle;
      payload_r <= in_req.payload[PAYLOAD_WIDTH-1:0];
    end
    if (load_out) begin
      nh_r   <= nh_nxt;
      ok_r   <= ok_nxt;
      pout_r <= pout_nxt;
      live_r <= COUNT_W'(alive_nxt);
      used_r <= COUNT_W'(hw_nxt);
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.new_handle  = nh_r;
  assign out_rsp.ok          = ok_r;
  assign out_rsp.payload_out = pout_r;
  assign out_rsp.live_total  = live_r;
  assign out_rsp.slots_used  = used_r;

  gha_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_q)
  );

  gha_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (SLOTS)
  ) u_payload_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (cur_idx),
    .wdata (payload_r),
    .re    (pay_re),
    .raddr (req_idx),
    .rdata (pay_q)
  );

  gha_free_stack #(
    .SLOTS (SLOTS)
  ) u_free_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (stk_ctl),
    .push_idx (cur_idx),
    .top_idx  (stk_top),
    .sts      (stk_sts)
  );

endmodule

FILE: rtl/core/gha_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/gha_free_stack.sv
// LIFO stack of freed slot indexes, kept in one RAM with a top pointer.
// Depends on gha_pkg and gha_ram.
module gha_free_stack #(
  parameter int SLOTS = 256,
  localparam int IDX_W = $clog2(SLOTS),
  localparam int CNT_W = $clog2(SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gha_pkg::stk_ctl_t ctl,
  input  logic [IDX_W-1:0]  push_idx,
  output logic [IDX_W-1:0]  top_idx,
  output gha_pkg::stk_sts_t sts
);
  import gha_pkg::*;

  logic [CNT_W-1:0] top_r;
  logic [CNT_W-1:0] top_nxt;
  logic [CNT_W-1:0] top_m1;

  assign top_m1 = top_r - CNT_W'(1);

  always_comb begin
    top_nxt = top_r;
    if (ctl.push) begin
      top_nxt = top_r + CNT_W'(1);
    end else if (ctl.pop) begin
      top_nxt = top_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
    end else begin
      top_r <= top_nxt;
    end
  end

  assign sts.empty = (top_r == '0);
  assign sts.full  = (top_r == CNT_W'(SLOTS));

  gha_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (top_r[IDX_W-1:0]),
    .wdata (push_idx),
    .re    (ctl.peek),
    .raddr (top_m1[IDX_W-1:0]),
    .rdata (top_idx)
  );

endmodule

FILE: rtl/core/gha_checker.sv
// Port-level checks of the generational handle allocator, bound to the top level.
// Depends on gha_pkg and generational_handle_allocator.
module gha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] new_handle,
  input logic        ok,
  input logic [63:0] payload_out
);
  import gha_pkg::*;

  a_handle_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (new_handle != '0) |-> ok)
    else $error("A nonzero handle was returned without ok.");

  a_handle_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (new_handle != '0) |-> (new_handle[INDEX_W-1:0] != '0))
    else $error("A returned handle has a zero index field.");

  a_data_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (payload_out != '0) |-> ok && (new_handle == '0))
    else $error("Data was returned without a successful get.");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(new_handle) && $stable(ok)
                               && $stable(payload_out))
    else $error("A stalled result word changed.");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .new_handle  (out_rsp.new_handle),
  .ok          (out_rsp.ok),
  .payload_out (out_rsp.payload_out)
);
